// File: design/v3n_pkg.sv
package v3n_pkg;

  localparam int unsigned COMPONENT_WIDTH    = 16;
  localparam int unsigned UNIT_FRACTION_BITS = 14;
  localparam int unsigned QUEUE_DEPTH        = 2;

endpackage

// File: design/v3n_in_if.sv
interface v3n_in_if #(
  parameter int unsigned CW = v3n_pkg::COMPONENT_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vec_x;
  logic signed [CW-1:0] vec_y;
  logic signed [CW-1:0] vec_z;

  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

// File: design/v3n_out_if.sv
interface v3n_out_if #(
  parameter int unsigned CW = v3n_pkg::COMPONENT_WIDTH,
  parameter int unsigned F  = v3n_pkg::UNIT_FRACTION_BITS
);
  logic                  valid;
  logic                  ready;
  logic signed [F+1:0]   unit_x;
  logic signed [F+1:0]   unit_y;
  logic signed [F+1:0]   unit_z;
  logic        [CW-1:0]  magnitude;
  logic                  zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, magnitude, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, magnitude, zero_length, output ready);
endinterface

// File: design/v3n_front.sv
// Registers an item, then forms magnitudes, signs and the sum of squares from it.
module v3n_front #(
  parameter int unsigned CW = v3n_pkg::COMPONENT_WIDTH,
  parameter int unsigned EW = 5 * CW + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [CW-1:0] vec_x_i,
  input  logic signed [CW-1:0] vec_y_i,
  input  logic signed [CW-1:0] vec_z_i,
  output logic                 push_o,
  input  logic                 full_i,
  output logic [EW-1:0]        entry_o
);
  localparam int unsigned SW = 2 * CW;

  logic                  vld_q;
  logic [3*CW-1:0]       raw_q;
  logic [CW-1:0]         mag   [3];
  logic [2:0]            neg;
  logic [SW-1:0]         sq    [3];
  logic [SW-1:0]         sum;

  assign ready_o = !vld_q || !full_i;
  assign push_o  = vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      raw_q <= {vec_z_i, vec_y_i, vec_x_i};
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg[c] = raw_q[c*CW + CW - 1];
      // two's complement negate; the most negative value maps onto itself as unsigned
      mag[c] = neg[c] ? (~raw_q[c*CW +: CW] + {{(CW-1){1'b0}}, 1'b1}) : raw_q[c*CW +: CW];
      sq[c]  = {{CW{1'b0}}, mag[c]} * {{CW{1'b0}}, mag[c]};
    end
    sum = sq[0] + sq[1] + sq[2];
  end

  assign entry_o = {(sum == '0), neg, mag[2], mag[1], mag[0], sum};
endmodule

// File: design/v3n_fifo.sv
module v3n_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = v3n_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_q [DEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [CNW-1:0] cnt_q;
  logic           do_wr, do_rd;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_rd) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

// File: design/v3n_back.sv
// Root pipeline (one root bit per stage) followed by a three-lane divide pipeline
// (one quotient bit per stage). The whole back end stalls as one when the output is held.
module v3n_back #(
  parameter int unsigned CW = v3n_pkg::COMPONENT_WIDTH,
  parameter int unsigned F  = v3n_pkg::UNIT_FRACTION_BITS,
  parameter int unsigned EW = 5 * CW + 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [EW-1:0]    entry_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [F+1:0]     unit_x_o,
  output logic [F+1:0]     unit_y_o,
  output logic [F+1:0]     unit_z_o,
  output logic [CW-1:0]    magnitude_o,
  output logic             zero_length_o
);
  localparam int unsigned SW  = 2 * CW;
  localparam int unsigned RW  = SW + 2 * F;
  localparam int unsigned RTW = RW / 2;
  localparam int unsigned NW  = CW + 2 * F + 2;
  localparam int unsigned QW  = F + 2;

  logic en;

  // root stages
  logic            s_vld_q [RTW+1];
  logic [RW-1:0]   v_q     [RTW+1];
  logic [RW-1:0]   r_q     [RTW+1];
  logic [3*CW-1:0] sa_q    [RTW+1];
  logic [2:0]      sn_q    [RTW+1];
  logic            sz_q    [RTW+1];

  // divide stages
  logic            d_vld_q [QW+1];
  logic [NW-1:0]   num_q   [QW+1][3];
  logic [NW-1:0]   den_q   [QW+1];
  logic [QW-1:0]   quo_q   [QW+1][3];
  logic [CW-1:0]   dm_q    [QW+1];
  logic [2:0]      dn_q    [QW+1];
  logic            dz_q    [QW+1];

  logic [RTW-1:0]  root;

  assign en    = !d_vld_q[QW] || ready_i;
  assign pop_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q[0] <= 1'b0;
    end else if (en) begin
      s_vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q[0]  <= {entry_i[SW-1:0], {(2*F){1'b0}}};
      r_q[0]  <= '0;
      sa_q[0] <= entry_i[SW +: 3*CW];
      sn_q[0] <= entry_i[SW + 3*CW +: 3];
      sz_q[0] <= entry_i[EW-1];
    end
  end

  for (genvar s = 0; s < RTW; s++) begin : g_root
    localparam int unsigned BP = RW - 2 - 2 * s;
    localparam logic [RW:0] BITV = {{RW{1'b0}}, 1'b1} << BP;
    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] v_nx, r_nx;

    assign trial = {1'b0, r_q[s]} + BITV;
    assign ge    = {1'b0, v_q[s]} >= trial;
    assign v_nx  = ge ? (v_q[s] - trial[RW-1:0]) : v_q[s];
    assign r_nx  = ge ? ((r_q[s] >> 1) + BITV[RW-1:0]) : (r_q[s] >> 1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s_vld_q[s+1] <= 1'b0;
      end else if (en) begin
        s_vld_q[s+1] <= s_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        v_q[s+1]  <= v_nx;
        r_q[s+1]  <= r_nx;
        sa_q[s+1] <= sa_q[s];
        sn_q[s+1] <= sn_q[s];
        sz_q[s+1] <= sz_q[s];
      end
    end
  end

  assign root = r_q[RTW][RTW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q[0] <= 1'b0;
    end else if (en) begin
      d_vld_q[0] <= s_vld_q[RTW];
    end
  end

  // numerator 2*a*2^(2F) + r over 2r gives the quotient rounded half away from zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        num_q[0][c] <= ({{(NW-CW){1'b0}}, sa_q[RTW][c*CW +: CW]} << (2*F + 1))
                       + {{(NW-RTW){1'b0}}, root};
        quo_q[0][c] <= '0;
      end
      den_q[0] <= {{(NW-RTW-1){1'b0}}, root, 1'b0};
      dm_q[0]  <= root[F +: CW];
      dn_q[0]  <= sn_q[RTW];
      dz_q[0]  <= sz_q[RTW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned K = QW - 1 - j;
    logic [NW-1:0] dsh;
    logic [NW-1:0] n_nx [3];
    logic [QW-1:0] q_nx [3];

    assign dsh = den_q[j] << K;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (num_q[j][c] >= dsh) begin
          n_nx[c] = num_q[j][c] - dsh;
          q_nx[c] = quo_q[j][c] | ({{(QW-1){1'b0}}, 1'b1} << K);
        end else begin
          n_nx[c] = num_q[j][c];
          q_nx[c] = quo_q[j][c];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        d_vld_q[j+1] <= d_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          num_q[j+1][c] <= n_nx[c];
          quo_q[j+1][c] <= q_nx[c];
        end
        den_q[j+1] <= den_q[j];
        dm_q[j+1]  <= dm_q[j];
        dn_q[j+1]  <= dn_q[j];
        dz_q[j+1]  <= dz_q[j];
      end
    end
  end

  // zero vector: divisor was zero, so the quotient is meaningless and forced to zero
  function automatic logic [QW-1:0] fix_unit(input logic [QW-1:0] q, input logic n,
                                             input logic z);
    logic [QW-1:0] r;
    r = z ? '0 : (n ? (~q + {{(QW-1){1'b0}}, 1'b1}) : q);
    return r;
  endfunction

  assign valid_o       = d_vld_q[QW];
  assign unit_x_o      = fix_unit(quo_q[QW][0], dn_q[QW][0], dz_q[QW]);
  assign unit_y_o      = fix_unit(quo_q[QW][1], dn_q[QW][1], dz_q[QW]);
  assign unit_z_o      = fix_unit(quo_q[QW][2], dn_q[QW][2], dz_q[QW]);
  assign magnitude_o   = dm_q[QW];
  assign zero_length_o = dz_q[QW];
endmodule

// File: design/vector3_normalize_top.sv
// 3-D vector normalizer: accepts one signed Q8.8 vector per cycle while the output is
// not held and returns the unit vector in signed Q1.14 plus the truncated length in Q8.8;
// a zero vector gives zeros and zero_length. Sustained rate is one item per cycle while
// the output is not held. The path is one input register, one queue slot, one root load
// stage, CW + F root stages (one root bit each), one divider load stage and F + 2 divide
// stages (one quotient bit each). A two-entry queue sits between the squaring front end
// and that back end.
module vector3_normalize_top #(
  parameter int unsigned COMPONENT_WIDTH    = v3n_pkg::COMPONENT_WIDTH,
  parameter int unsigned UNIT_FRACTION_BITS = v3n_pkg::UNIT_FRACTION_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  v3n_in_if.sink     in_i,
  v3n_out_if.source  out_o
);
  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned F  = UNIT_FRACTION_BITS;
  localparam int unsigned EW = 5 * CW + 4;

  logic          push, full, pop, q_valid;
  logic [EW-1:0] f_entry, q_entry;

  v3n_front #(.CW(CW), .EW(EW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .vec_x_i (in_i.vec_x),
    .vec_y_i (in_i.vec_y),
    .vec_z_i (in_i.vec_z),
    .push_o  (push),
    .full_i  (full),
    .entry_o (f_entry)
  );

  v3n_fifo #(.W(EW), .DEPTH(v3n_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_entry)
  );

  v3n_back #(.CW(CW), .F(F), .EW(EW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (q_entry),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .unit_x_o      (out_o.unit_x),
    .unit_y_o      (out_o.unit_y),
    .unit_z_o      (out_o.unit_z),
    .magnitude_o   (out_o.magnitude),
    .zero_length_o (out_o.zero_length)
  );
endmodule

// File: design/v3n_checker.sv
module v3n_checker #(
  parameter int unsigned CW = v3n_pkg::COMPONENT_WIDTH,
  parameter int unsigned F  = v3n_pkg::UNIT_FRACTION_BITS
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                valid_i,
  input logic                ready_i,
  input logic signed [F+1:0] unit_x_i,
  input logic signed [F+1:0] unit_y_i,
  input logic signed [F+1:0] unit_z_i,
  input logic [CW-1:0]       magnitude_i,
  input logic                zero_length_i
);
  localparam logic signed [F+1:0] UMAX = {2'b01, {F{1'b0}}};
  localparam logic signed [F+1:0] UMIN = -UMAX;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(magnitude_i) && $stable(unit_x_i))
    else $error("output item changed while stalled");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && zero_length_i |-> unit_x_i == '0 && unit_y_i == '0 && unit_z_i == '0
                                 && magnitude_i == '0)
    else $error("zero vector with nonzero outputs");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !zero_length_i |-> magnitude_i != '0)
    else $error("nonzero vector with zero length");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> unit_x_i <= UMAX && unit_x_i >= UMIN && unit_y_i <= UMAX
                && unit_y_i >= UMIN && unit_z_i <= UMAX && unit_z_i >= UMIN)
    else $error("unit component out of range");
endmodule

bind vector3_normalize_top v3n_checker #(.CW(COMPONENT_WIDTH), .F(UNIT_FRACTION_BITS)) u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .unit_x_i      (out_o.unit_x),
  .unit_y_i      (out_o.unit_y),
  .unit_z_i      (out_o.unit_z),
  .magnitude_i   (out_o.magnitude),
  .zero_length_i (out_o.zero_length)
);

// File: sim/tb_vector3_normalize_top.sv
`timescale 1ns / 1ps

module tb_vector3_normalize_top;

  localparam int unsigned CW = v3n_pkg::COMPONENT_WIDTH;
  localparam int unsigned F  = v3n_pkg::UNIT_FRACTION_BITS;
  localparam int unsigned LATENCY = CW + 2 * F + 5;
  localparam int unsigned N_RANDOM = 1040;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic signed [F+1:0] ux;
    logic signed [F+1:0] uy;
    logic signed [F+1:0] uz;
    logic [CW-1:0]       mag;
    logic                zl;
  } norm_t;

  typedef struct {
    comp_t x, y, z;
    bit    typed;
    norm_t res;
  } vec_row_t;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  bit   no_idle;
  bit   hold_req;
  norm_t norm_q[$];

  v3n_in_if  in_if ();
  v3n_out_if out_if ();

  vector3_normalize_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [F+1:0] unit_of(comp_t c, longint unsigned r);
    longint unsigned a, q;
    a = (c < 0) ? longint'(-longint'(c)) : longint'(c);
    q = ((a << (2 * F + 1)) + r) / (r << 1);
    if (c < 0) q = -q;
    return q[F+1:0];
  endfunction

  function automatic norm_t normalize(comp_t x, comp_t y, comp_t z);
    norm_t n;
    longint unsigned sum, r;
    sum = longint'(x) * longint'(x) + longint'(y) * longint'(y)
        + longint'(z) * longint'(z);
    if (sum == 0) begin
      n = '0;
      n.zl = 1'b1;
      return n;
    end
    r = root_floor(sum << (2 * F));
    n.ux  = unit_of(x, r);
    n.uy  = unit_of(y, r);
    n.uz  = unit_of(z, r);
    n.mag = CW'(r >> F);
    n.zl  = 1'b0;
    return n;
  endfunction

  // receiver: checks at the edge, then picks ready for the next cycle
  initial begin
    int stall;
    norm_t e;
    stall = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (norm_q.size() == 0) begin
          $error("unexpected item out");
          err_cnt++;
        end else begin
          e = norm_q.pop_front();
          if (out_if.unit_x !== e.ux) begin
            $error("unit_x exp %0d got %0d", e.ux, out_if.unit_x); err_cnt++;
          end
          if (out_if.unit_y !== e.uy) begin
            $error("unit_y exp %0d got %0d", e.uy, out_if.unit_y); err_cnt++;
          end
          if (out_if.unit_z !== e.uz) begin
            $error("unit_z exp %0d got %0d", e.uz, out_if.unit_z); err_cnt++;
          end
          if (out_if.magnitude !== e.mag) begin
            $error("magnitude exp %0d got %0d", e.mag, out_if.magnitude); err_cnt++;
          end
          if (out_if.zero_length !== e.zl) begin
            $error("zero_length exp %0d got %0d", e.zl, out_if.zero_length); err_cnt++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_vec(comp_t x, comp_t y, comp_t z, bit typed, norm_t res);
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.vec_x <= x;
    in_if.vec_y <= y;
    in_if.vec_z <= z;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    norm_q.push_back(typed ? res : normalize(x, y, z));
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return comp_t'($urandom_range(0, 15)) - comp_t'(8);
      2: return $urandom_range(0, 1) ? comp_t'(16'h8000) : comp_t'(16'h7fff);
      3: return comp_t'($urandom_range(0, 1023)) - comp_t'(512);
      default: return comp_t'($urandom());
    endcase
  endfunction

  initial begin
    vec_row_t rows[$];
    norm_t zero_res, neg_x_res;
    comp_t x, y, z;
    err_cnt  = 0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.vec_x = '0;
    in_if.vec_y = '0;
    in_if.vec_z = '0;

    zero_res = '0;
    zero_res.zl = 1'b1;
    // -1.0 * 2^15 along x: root is exact, unit is -1.0
    neg_x_res = '{ux: -16384, uy: 0, uz: 0, mag: 16'd32768, zl: 1'b0};
    rows = '{
      '{x: 0, y: 0, z: 0, typed: 1, res: zero_res},
      '{x: -32768, y: 0, z: 0, typed: 1, res: neg_x_res},
      '{x: 32767, y: 0, z: 0, typed: 0, res: '0},
      '{x: 0, y: 32767, z: 0, typed: 0, res: '0},
      '{x: 0, y: 0, z: -32768, typed: 0, res: '0},
      '{x: -32768, y: -32768, z: -32768, typed: 0, res: '0},
      '{x: 32767, y: 32767, z: 32767, typed: 0, res: '0},
      '{x: 1, y: 0, z: 0, typed: 0, res: '0},
      '{x: -1, y: -1, z: -1, typed: 0, res: '0},
      '{x: 1, y: 1, z: 0, typed: 0, res: '0},
      '{x: 0, y: 0, z: 0, typed: 1, res: zero_res},
      '{x: 3, y: -4, z: 12, typed: 0, res: '0},
      '{x: 32767, y: -32768, z: 1, typed: 0, res: '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_req = 1'b1;
      if (n == 500) begin
        in_if.valid <= 1'b0;
        while (norm_q.size() != 0) @(posedge clk_i);
      end
      if (n == 900) no_idle = 1'b1;
      x = rand_comp();
      y = rand_comp();
      z = rand_comp();
      send_vec(x, y, z, 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (norm_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
